// ===== sv/tpd_pkg.sv =====
// Shared types and constants for the two-channel triac phase dimmer.
// Used by tpd_chan and two_channel_triac_phase_dimmer_top; depends on nothing.
package tpd_pkg;

	localparam int NUM_CH    = 2;
	localparam int TIME_W    = 16;
	localparam int PCT_W     = 7;
	localparam int IDX_W     = 3;
	localparam int PROD_W    = TIME_W + PCT_W;
	// Reciprocal of 100 scaled by 2^30, rounded up; exact for every product below 2^23.
	localparam int RECIP_W   = 24;
	localparam int RECIP_SH  = 30;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

	localparam logic [7:0]        PCT_FULL   = 8'd100;
	localparam logic [TIME_W-1:0] TIME_MAX   = 16'hFFFF;

	localparam logic [TIME_W-1:0] RST_DELAY_MIN   = 16'd200;
	localparam logic [TIME_W-1:0] RST_DELAY_MAX   = 16'd9000;
	localparam logic [TIME_W-1:0] RST_PULSE_TICKS = 16'd100;
	localparam logic              RST_ZC_FALLING  = 1'b1;
	localparam logic [NUM_CH-1:0] RST_CH_ENABLE   = 2'b11;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	localparam logic [IDX_W-1:0] REG_DELAY_MIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_DELAY_MAX   = 3'd1;
	localparam logic [IDX_W-1:0] REG_PULSE_TICKS = 3'd2;
	localparam logic [IDX_W-1:0] REG_ZC_FALLING  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CH_ENABLE   = 3'd4;

	// Per-channel control for the item that is being retired this cycle.
	typedef struct packed {
		logic              tick;
		logic              set;
		logic              edge_arm;
		logic [PCT_W-1:0]  pct;
		logic [TIME_W-1:0] delay;
		logic [TIME_W-1:0] pulse_ticks;
	} tpd_ctl_t;

endpackage

// ===== sv/tpd_chan.sv =====
// One dimmer channel: stored percent and delay, phase counter, arm flag, gate pulse.
// Depends on tpd_pkg for tpd_ctl_t and widths.
module tpd_chan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpd_pkg::tpd_ctl_t          ctl,
	output logic                       gate,
	output logic [tpd_pkg::PCT_W-1:0]  pct_nxt
);

	logic [tpd_pkg::PCT_W-1:0]  pct_q;
	logic [tpd_pkg::TIME_W-1:0] delay_q;
	logic [tpd_pkg::TIME_W-1:0] cnt_q;
	logic                       armed_q;
	logic [tpd_pkg::TIME_W-1:0] pulse_q;

	logic                       armed_e;
	logic [tpd_pkg::TIME_W-1:0] cnt_e;
	logic                       fire;
	logic [tpd_pkg::TIME_W-1:0] pulse_e;
	logic                       tick_gate;
	logic                       armed_n;
	logic [tpd_pkg::TIME_W-1:0] cnt_n;
	logic [tpd_pkg::TIME_W-1:0] pulse_n;

	always_comb begin
		armed_e   = armed_q | ctl.edge_arm;
		cnt_e     = ctl.edge_arm ? '0 : cnt_q;
		fire      = armed_e && (cnt_e == delay_q);
		pulse_e   = fire ? ctl.pulse_ticks : pulse_q;
		tick_gate = (pulse_e != '0);
		pulse_n   = tick_gate ? pulse_e - 1'b1 : '0;
		armed_n   = armed_e & ~fire;
		// The counter runs only while armed and sticks at its maximum.
		if (armed_e && !fire && cnt_e != tpd_pkg::TIME_MAX) begin
			cnt_n = cnt_e + 1'b1;
		end else begin
			cnt_n = cnt_e;
		end
		gate    = ctl.tick ? tick_gate : (pulse_q != '0);
		pct_nxt = ctl.set ? ctl.pct : pct_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q   <= '0;
			delay_q <= '0;
			cnt_q   <= '0;
			armed_q <= 1'b0;
			pulse_q <= '0;
		end else begin
			if (ctl.set) begin
				pct_q   <= ctl.pct;
				delay_q <= ctl.delay;
			end
			if (ctl.tick) begin
				cnt_q   <= cnt_n;
				armed_q <= armed_n;
				pulse_q <= pulse_n;
			end
		end
	end

endmodule

// ===== sv/two_channel_triac_phase_dimmer_top.sv =====
// Two-channel triac phase dimmer: one result per item, one item per cycle while
// out_ready drains the result register. The span-times-percent product is formed
// ahead of the input register; the divide by 100 and the channel update sit
// between the input register and the result register.
// Reset (arst_n low) clears all channel state and loads the register defaults.
// Depends on tpd_pkg and tpd_chan.
module two_channel_triac_phase_dimmer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tpd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [tpd_pkg::TIME_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic                        zc_level,
	input  logic                        channel,
	input  logic [7:0]                  percent,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        gate_a,
	output logic                        gate_b,
	output logic [tpd_pkg::PCT_W-1:0]   percent_read
);

	logic [tpd_pkg::TIME_W-1:0] delay_min_q;
	logic [tpd_pkg::TIME_W-1:0] delay_max_q;
	logic [tpd_pkg::TIME_W-1:0] pulse_ticks_q;
	logic                       zc_falling_q;
	logic [tpd_pkg::NUM_CH-1:0] ch_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_min_q   <= tpd_pkg::RST_DELAY_MIN;
			delay_max_q   <= tpd_pkg::RST_DELAY_MAX;
			pulse_ticks_q <= tpd_pkg::RST_PULSE_TICKS;
			zc_falling_q  <= tpd_pkg::RST_ZC_FALLING;
			ch_enable_q   <= tpd_pkg::RST_CH_ENABLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpd_pkg::REG_DELAY_MIN:   delay_min_q   <= cfg_wdata;
				tpd_pkg::REG_DELAY_MAX:   delay_max_q   <= cfg_wdata;
				tpd_pkg::REG_PULSE_TICKS: pulse_ticks_q <= cfg_wdata;
				tpd_pkg::REG_ZC_FALLING:  zc_falling_q  <= cfg_wdata[0];
				tpd_pkg::REG_CH_ENABLE:   ch_enable_q   <= cfg_wdata[tpd_pkg::NUM_CH-1:0];
				default: ;
			endcase
		end
	end

	// Input side: clamp the percent and form the product for the delay.
	logic [tpd_pkg::PCT_W-1:0]  pct_clamp;
	logic [tpd_pkg::TIME_W-1:0] span;
	logic                       reversed;

	always_comb begin
		pct_clamp = (percent > tpd_pkg::PCT_FULL) ? tpd_pkg::PCT_FULL[tpd_pkg::PCT_W-1:0]
		                                          : percent[tpd_pkg::PCT_W-1:0];
		reversed  = (delay_max_q < delay_min_q);
		span      = delay_max_q - delay_min_q;
	end

	logic                        vld_s1;
	logic                        cmd_s1;
	logic                        zc_s1;
	logic                        ch_s1;
	logic [tpd_pkg::PCT_W-1:0]   pct_s1;
	logic [tpd_pkg::PROD_W-1:0]  prod_s1;
	logic                        rev_s1;
	logic                        advance;

	assign advance  = vld_s1 && (!out_valid || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			zc_s1   <= zc_level;
			ch_s1   <= channel;
			pct_s1  <= pct_clamp;
			prod_s1 <= {{tpd_pkg::PCT_W{1'b0}}, span} * {{tpd_pkg::TIME_W{1'b0}}, pct_clamp};
			rev_s1  <= reversed;
		end
	end

	// Divide by 100 (scaled reciprocal), subtract from max; use min if reversed.
	logic [tpd_pkg::PROD_W+tpd_pkg::RECIP_W-1:0] recip_prod;
	logic [tpd_pkg::TIME_W-1:0]                  quot;
	logic [tpd_pkg::TIME_W-1:0]                  delay_new;

	always_comb begin
		recip_prod = {{tpd_pkg::RECIP_W{1'b0}}, prod_s1} *
		             {{tpd_pkg::PROD_W{1'b0}}, tpd_pkg::RECIP_100};
		quot       = recip_prod[tpd_pkg::RECIP_SH +: tpd_pkg::TIME_W];
		delay_new  = rev_s1 ? delay_min_q : delay_max_q - quot;
	end

	logic zc_prev_q;
	logic zc_edge;

	assign zc_edge = zc_falling_q ? (zc_prev_q && !zc_s1) : (!zc_prev_q && zc_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_prev_q <= 1'b0;
		end else if (advance && cmd_s1 == tpd_pkg::CMD_TICK) begin
			zc_prev_q <= zc_s1;
		end
	end

	tpd_pkg::tpd_ctl_t          ctl [tpd_pkg::NUM_CH];
	logic [tpd_pkg::NUM_CH-1:0] gate_nxt;
	logic [tpd_pkg::PCT_W-1:0]  pct_nxt [tpd_pkg::NUM_CH];

	for (genvar c = 0; c < tpd_pkg::NUM_CH; c++) begin : g_chan
		always_comb begin
			ctl[c].tick        = advance && (cmd_s1 == tpd_pkg::CMD_TICK);
			ctl[c].set         = advance && (cmd_s1 == tpd_pkg::CMD_SET) && (ch_s1 == 1'(c));
			ctl[c].edge_arm    = zc_edge && ch_enable_q[c];
			ctl[c].pct         = pct_s1;
			ctl[c].delay       = delay_new;
			ctl[c].pulse_ticks = pulse_ticks_q;
		end

		tpd_chan u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[c]),
			.gate    (gate_nxt[c]),
			.pct_nxt (pct_nxt[c])
		);
	end

	// Result register: holds a finished result while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gate_a       <= gate_nxt[0];
			gate_b       <= gate_nxt[1];
			percent_read <= pct_nxt[ch_s1];
		end
	end

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while both stages are full");

	a_retire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("retired item produced no result");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 |-> pct_s1 <= tpd_pkg::PCT_FULL[tpd_pkg::PCT_W-1:0]) and
		(out_valid |-> percent_read <= tpd_pkg::PCT_FULL[tpd_pkg::PCT_W-1:0]))
		else $error("percent above full scale");

endmodule
